>>> rtl/umreu_pkg.sv
`timescale 1ns / 1ps

package umreu_pkg;

  // Machine word and field widths.
  localparam int XLEN     = 32;
  localparam int CMD_W    = 4;
  localparam int IMM_W    = 25;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;

  // Default size of the register file.
  localparam int NUM_REGS_DEF = 8;

  // Instruction opcodes.
  localparam logic [CMD_W-1:0] OP_CMOV     = 4'd0;
  localparam logic [CMD_W-1:0] OP_LOAD     = 4'd1;
  localparam logic [CMD_W-1:0] OP_STORE    = 4'd2;
  localparam logic [CMD_W-1:0] OP_ADD      = 4'd3;
  localparam logic [CMD_W-1:0] OP_MUL      = 4'd4;
  localparam logic [CMD_W-1:0] OP_DIV      = 4'd5;
  localparam logic [CMD_W-1:0] OP_NAND     = 4'd6;
  localparam logic [CMD_W-1:0] OP_HALT     = 4'd7;
  localparam logic [CMD_W-1:0] OP_MAP      = 4'd8;
  localparam logic [CMD_W-1:0] OP_UNMAP    = 4'd9;
  localparam logic [CMD_W-1:0] OP_OUT      = 4'd10;
  localparam logic [CMD_W-1:0] OP_IN       = 4'd11;
  localparam logic [CMD_W-1:0] OP_LOADPROG = 4'd12;
  localparam logic [CMD_W-1:0] OP_LOADVAL  = 4'd13;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BIGCHAR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADOP   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_HALT    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_PASSED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_STOPPED = 3'd6;

  // Largest character value that may be emitted.
  localparam logic [XLEN-1:0] CHAR_MAX = 32'd255;

endpackage

>>> rtl/um_register_execute_unit_top.sv
`timescale 1ns / 1ps
// An accepted instruction goes from the read state, which takes operands from the registered read
// ports, to the done state for register moves, I/O, jumps, status-only operations and division by
// zero; add, nand, multiply and divide run 32 iterations of a serial loop in between (one bit or
// one shift-add/subtract step a cycle). Once stopped, the machine goes from idle straight to done.
// A new instruction is taken the cycle after the previous result loads into the output
// register. Reset clears the program counter, the stop flag, the register valid bits and control.
module um_register_execute_unit_top #(
  parameter int NUM_REGS = umreu_pkg::NUM_REGS_DEF,
  localparam int IDX_W = $clog2(NUM_REGS)
) (
  input  logic                              clk,
  input  logic                              rst,
  // Instruction channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [umreu_pkg::CMD_W-1:0]       cmd,
  input  logic [IDX_W-1:0]                  reg_a,
  input  logic [IDX_W-1:0]                  reg_b,
  input  logic [IDX_W-1:0]                  reg_c,
  input  logic [umreu_pkg::IMM_W-1:0]       imm_value,
  input  logic [umreu_pkg::CHAR_W-1:0]      in_char,
  input  logic                              in_eof,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [umreu_pkg::XLEN-1:0]        next_pc,
  output logic                              char_valid,
  output logic [umreu_pkg::CHAR_W-1:0]      char_out,
  output logic [umreu_pkg::STATUS_W-1:0]    status
);

  localparam int XLEN  = umreu_pkg::XLEN;
  localparam int CNT_W = $clog2(XLEN);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                     state;
  logic [CNT_W-1:0]               cnt;
  logic                           stopped;
  logic [XLEN-1:0]                pc;

  // Register file storage with per-entry valid bits.
  logic [XLEN-1:0]                regs [NUM_REGS];
  logic [NUM_REGS-1:0]            vld;
  logic [XLEN-1:0]                rd_b;
  logic [XLEN-1:0]                rd_c;

  // Instruction fields held for the duration of the operation.
  logic [umreu_pkg::CMD_W-1:0]    cmd_r;
  logic [IDX_W-1:0]               a_r;
  logic [IDX_W-1:0]               c_r;
  logic [umreu_pkg::IMM_W-1:0]    imm_r;
  logic [umreu_pkg::CHAR_W-1:0]   ch_r;
  logic                           eof_r;

  // Serial datapath and pending result.
  logic [XLEN-1:0]                sh_b;
  logic [XLEN-1:0]                sh_c;
  logic [XLEN-1:0]                res;
  logic [XLEN-1:0]                rem;
  logic                           carry;
  logic                           wen_r;
  logic [IDX_W-1:0]               wa_r;
  logic [XLEN-1:0]                npc_r;
  logic [umreu_pkg::STATUS_W-1:0] st_r;
  logic                           cv_r;
  logic [umreu_pkg::CHAR_W-1:0]   co_r;

  logic                           in_fire;
  logic                           done_fire;
  logic [1:0]                     add_sum;
  logic [XLEN:0]                  trial;
  logic [XLEN:0]                  diff;
  logic                           stop_set;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign done_fire = (state == S_DONE) && (!out_valid || out_ready);

  // Serial add bit, and one restoring division step.
  assign add_sum = {1'b0, sh_b[0]} + {1'b0, sh_c[0]} + {1'b0, carry};
  assign trial   = {rem, sh_b[XLEN-1]};
  assign diff    = trial - {1'b0, sh_c};

  assign stop_set = (st_r == umreu_pkg::ST_DIVZERO) || (st_r == umreu_pkg::ST_BIGCHAR) ||
                    (st_r == umreu_pkg::ST_BADOP) || (st_r == umreu_pkg::ST_HALT);

  // True when the operation needs the 32-step serial loop.
  function automatic logic wen_r_next_run(input logic [umreu_pkg::CMD_W-1:0] op,
                                          input logic [XLEN-1:0] c_val);
    logic run;
    run = 1'b0;
    unique case (op) inside
      umreu_pkg::OP_ADD, umreu_pkg::OP_MUL, umreu_pkg::OP_NAND: run = 1'b1;
      umreu_pkg::OP_DIV: run = (c_val != '0);
      default: run = 1'b0;
    endcase
    return run;
  endfunction

  // Register file read ports, registered; an unwritten entry reads as zero.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_b <= vld[reg_b] ? regs[reg_b] : '0;
      rd_c <= vld[reg_c] ? regs[reg_c] : '0;
    end
  end

  // Register file write port.
  always_ff @(posedge clk) begin
    if (done_fire && wen_r) begin
      regs[wa_r] <= res;
    end
  end

  // Control state: sequencer, counter, valid bits, program counter, stop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      vld     <= '0;
      pc      <= '0;
      stopped <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= stopped ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          cnt <= '0;
          if (wen_r_next_run(cmd_r, rd_c)) begin
            state <= S_RUN;
          end else begin
            state <= S_DONE;
          end
        end
        S_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(XLEN - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            state <= S_IDLE;
            pc    <= npc_r;
            if (wen_r) begin
              vld[wa_r] <= 1'b1;
            end
            if (stop_set) begin
              stopped <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: field capture, operation decode, serial loop.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd_r <= cmd;
          a_r   <= reg_a;
          c_r   <= reg_c;
          imm_r <= imm_value;
          ch_r  <= in_char;
          eof_r <= in_eof;
          // A stopped machine answers with its frozen program counter.
          wen_r <= 1'b0;
          wa_r  <= reg_a;
          npc_r <= pc;
          st_r  <= umreu_pkg::ST_STOPPED;
          cv_r  <= 1'b0;
          co_r  <= '0;
        end
      end
      S_READ: begin
        sh_b  <= rd_b;
        sh_c  <= rd_c;
        res   <= '0;
        rem   <= '0;
        carry <= 1'b0;
        wen_r <= 1'b0;
        wa_r  <= a_r;
        npc_r <= pc + 1'b1;
        st_r  <= umreu_pkg::ST_OK;
        cv_r  <= 1'b0;
        co_r  <= '0;
        unique case (cmd_r) inside
          umreu_pkg::OP_CMOV: begin
            wen_r <= (rd_c != '0);
            res   <= rd_b;
          end
          umreu_pkg::OP_LOAD, umreu_pkg::OP_STORE, umreu_pkg::OP_MAP,
          umreu_pkg::OP_UNMAP: begin
            st_r <= umreu_pkg::ST_PASSED;
          end
          umreu_pkg::OP_ADD, umreu_pkg::OP_MUL, umreu_pkg::OP_NAND: begin
            wen_r <= 1'b1;
          end
          umreu_pkg::OP_DIV: begin
            if (rd_c == '0) begin
              st_r <= umreu_pkg::ST_DIVZERO;
            end else begin
              wen_r <= 1'b1;
            end
          end
          umreu_pkg::OP_HALT: begin
            st_r <= umreu_pkg::ST_HALT;
          end
          umreu_pkg::OP_OUT: begin
            if (rd_c > umreu_pkg::CHAR_MAX) begin
              st_r <= umreu_pkg::ST_BIGCHAR;
            end else begin
              cv_r <= 1'b1;
              co_r <= rd_c[umreu_pkg::CHAR_W-1:0];
            end
          end
          umreu_pkg::OP_IN: begin
            wen_r <= 1'b1;
            wa_r  <= c_r;
            res   <= eof_r ? '1 : XLEN'(ch_r);
          end
          umreu_pkg::OP_LOADPROG: begin
            if (rd_b != '0) begin
              st_r <= umreu_pkg::ST_PASSED;
            end
            npc_r <= rd_c;
          end
          umreu_pkg::OP_LOADVAL: begin
            wen_r <= 1'b1;
            res   <= XLEN'(imm_r);
          end
          default: begin
            st_r <= umreu_pkg::ST_BADOP;
          end
        endcase
      end
      S_RUN: begin
        case (cmd_r)
          umreu_pkg::OP_ADD: begin
            res   <= {add_sum[0], res[XLEN-1:1]};
            carry <= add_sum[1];
            sh_b  <= sh_b >> 1;
            sh_c  <= sh_c >> 1;
          end
          umreu_pkg::OP_NAND: begin
            res  <= {~(sh_b[0] & sh_c[0]), res[XLEN-1:1]};
            sh_b <= sh_b >> 1;
            sh_c <= sh_c >> 1;
          end
          umreu_pkg::OP_MUL: begin
            if (sh_c[0]) begin
              res <= res + sh_b;
            end
            sh_b <= sh_b << 1;
            sh_c <= sh_c >> 1;
          end
          umreu_pkg::OP_DIV: begin
            // Divisor stays in sh_c; dividend bits leave sh_b from the top.
            if (!diff[XLEN]) begin
              rem <= diff[XLEN-1:0];
              res <= {res[XLEN-2:0], 1'b1};
            end else begin
              rem <= trial[XLEN-1:0];
              res <= {res[XLEN-2:0], 1'b0};
            end
            sh_b <= sh_b << 1;
          end
          default: begin
            res <= res;
          end
        endcase
      end
      default: begin
        res <= res;
      end
    endcase
  end

  // Output register; a new result loads once the previous one is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      next_pc    <= npc_r;
      char_valid <= cv_r;
      char_out   <= co_r;
      status     <= st_r;
    end
  end

  // The stop flag is sticky until reset.
  assert property (@(posedge clk) disable iff (rst) stopped |=> stopped)
    else $error("stop flag cleared without reset");

  // A character is only emitted by a successful instruction.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && char_valid |-> status == umreu_pkg::ST_OK)
    else $error("character emitted with error status");

  // Once stopped, every new result reports the stopped status and the frozen counter.
  assert property (@(posedge clk) disable iff (rst)
                   done_fire && stopped |=> status == umreu_pkg::ST_STOPPED && next_pc == pc)
    else $error("stopped machine produced a live result");

  // The iteration counter is idle at zero outside the serial loop.
  assert property (@(posedge clk) disable iff (rst) state != S_RUN |-> cnt == '0)
    else $error("iteration counter out of step with sequencer");

endmodule
